[hw/rtl/tpst_pkg.sv]
// ----------------------------------------------------------------------------
// tpst_pkg
// Shared types, field widths, operation codes and estimate constants for the
// token prefix-sum table.
// ----------------------------------------------------------------------------
package tpst_pkg;

    // Default table capacity
    localparam int MAX_ENTRIES_DEF = 1024;

    // Field widths
    localparam int MODE_W = 3;
    localparam int LEN_W  = 24;
    localparam int EST_W  = 32;
    localparam int IDX_W  = 11;
    localparam int SUM_W  = 42;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_APPEND_EST = 3'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND_LEN = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUFFIX_SUM = 3'd2;
    localparam logic [MODE_W-1:0] MODE_KEEP_RECENT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Estimate from length: ceil(ceil(len/4) * 221 / 200)
    localparam int LEN_BIAS  = 3;
    localparam int LEN_SHIFT = 2;
    localparam int EST_MUL   = 221;
    localparam int EST_BIAS  = 199;
    localparam int EST_DIV   = 200;
    localparam int X_W       = 30;

    // Reciprocal of the divisor, scaled by 2^RECIP_SHIFT and rounded down
    localparam int RECIP_SHIFT = 38;
    localparam int RECIP_W     = 31;
    localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SHIFT) / EST_DIV;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    // One input item
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LEN_W-1:0]  text_length;
        logic [EST_W-1:0]  given_estimate;
        logic [IDX_W-1:0]  first_entry;
        logic [SUM_W-1:0]  token_budget;
    } request_t;

    // One result item
    typedef struct packed {
        logic             status;
        logic [SUM_W-1:0] answer;
        logic [IDX_W-1:0] entry_count;
    } result_t;

    // Memory port controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EST_MUL,
        ST_EST_FIX,
        ST_APPEND,
        ST_SUF_WAIT,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_RESULT
    } state_t;

endpackage

[hw/rtl/tpst_prefix_ram.sv]
// ----------------------------------------------------------------------------
// tpst_prefix_ram
// Prefix-sum store: one write port, one read port with registered data.
// Entry zero is not stored and always reads as zero.
// ----------------------------------------------------------------------------
module tpst_prefix_ram #(
    parameter int DEPTH  = tpst_pkg::MAX_ENTRIES_DEF + 1,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = tpst_pkg::SUM_W
) (
    input  logic               clk,
    input  tpst_pkg::ram_ctl_t ctl,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [DATA_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [DATA_W-1:0]  rd_data
);
    import tpst_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_zero_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port: capture data and flag entry zero
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_zero_reg <= (rd_addr == '0);
        end
    end

    // Entry zero holds the empty sum
    assign rd_data = rd_zero_reg ? '0 : rd_data_reg;

endmodule

[hw/rtl/token_prefix_sum_table.sv]
// ----------------------------------------------------------------------------
// token_prefix_sum_table
// Running prefix-sum table of token estimates with append, suffix-sum,
// keep-recent search and clear operations.
// ----------------------------------------------------------------------------
// Append estimate decodes then appends; append by length adds a multiply
// and a fix step; suffix sum reads the store unless the start lies past the
// count; keep recent answers at decode when the budget covers the table,
// else binary-searches, one memory read per search step; clear and spare
// modes answer at decode. busy drops the cycle after the result strobe; only
// then is a new item taken. The receiver cannot stall. Reset empties the table.
module token_prefix_sum_table #(
    parameter int MAX_ENTRIES = tpst_pkg::MAX_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  tpst_pkg::request_t request,
    output logic               busy,
    output logic               done,
    output tpst_pkg::result_t  response
);
    import tpst_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = CNT_W;
    localparam int DEPTH  = MAX_ENTRIES + 1;
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int PROD_W = X_W + RECIP_W;
    localparam int Q_W    = PROD_W - RECIP_SHIFT;
    localparam int BASE_W = LEN_W + 1 - LEN_SHIFT;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    state_t              state_reg, state_next;
    request_t            req_reg, req_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    total_reg, total_next;
    logic [EST_W-1:0]    est_reg, est_next;
    logic [X_W-1:0]      x_reg, x_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    mid_reg, mid_next;
    logic [SUM_W-1:0]    thr_reg, thr_next;
    logic                status_reg, status_next;
    logic [SUM_W-1:0]    answer_reg, answer_next;

    ram_ctl_t            ram_ctl;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SUM_W-1:0]    wr_data;
    logic [ADDR_W-1:0]   rd_addr;
    logic [SUM_W-1:0]    rd_data;

    logic [LEN_W:0]      len_sum;
    logic [BASE_W-1:0]   len_base;
    logic [X_W-1:0]      x_calc;
    logic [Q_W-1:0]      quot;
    logic [X_W-1:0]      quot_times;
    logic [X_W-1:0]      remain;
    logic [EST_W-1:0]    est_fix;
    logic [CMP_W-1:0]    start_ext;
    logic [CMP_W-1:0]    start_eff;
    logic [CMP_W-1:0]    count_ext;
    logic [CMP_W-1:0]    suf_addr_full;
    logic                start_past;
    logic                keep_direct;
    logic [CNT_W-1:0]    mid_calc;

    // Prefix-sum store
    tpst_prefix_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (SUM_W)
    ) u_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Estimate from length: round up to quarters, scale, divide by reciprocal
    assign len_sum    = {1'b0, req_reg.text_length} + (LEN_W + 1)'(LEN_BIAS);
    assign len_base   = len_sum[LEN_W:LEN_SHIFT];
    assign x_calc     = X_W'(len_base * EST_MUL + EST_BIAS);
    assign quot       = prod_reg[PROD_W-1:RECIP_SHIFT];
    assign quot_times = X_W'(quot * EST_DIV);
    assign remain     = x_reg - quot_times;
    assign est_fix    = EST_W'(quot) + EST_W'(remain >= X_W'(EST_DIV));

    // Suffix start: clamp up to one, check against the count
    assign start_ext     = CMP_W'(req_reg.first_entry);
    assign start_eff     = (start_ext == '0) ? CMP_W'(1) : start_ext;
    assign count_ext     = CMP_W'(count_reg);
    assign start_past    = start_eff > count_ext;
    assign suf_addr_full = start_eff - CMP_W'(1);

    // Keep recent: whole table fits, or the midpoint of the search window
    assign keep_direct = req_reg.token_budget >= total_reg;
    assign mid_calc    = lo_reg + ((hi_reg - lo_reg) >> 1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (req_reg.mode)
                    MODE_APPEND_EST:  state_next = ST_APPEND;
                    MODE_APPEND_LEN:  state_next = ST_EST_MUL;
                    MODE_SUFFIX_SUM:  state_next = start_past ? ST_RESULT : ST_SUF_WAIT;
                    MODE_KEEP_RECENT: state_next = keep_direct ? ST_RESULT : ST_SRCH_RD;
                    default:          state_next = ST_RESULT;
                endcase
            end
            ST_EST_MUL:  state_next = ST_EST_FIX;
            ST_EST_FIX:  state_next = ST_APPEND;
            ST_APPEND:   state_next = ST_RESULT;
            ST_SUF_WAIT: state_next = ST_RESULT;
            ST_SRCH_RD:  state_next = (lo_reg < hi_reg) ? ST_SRCH_CMP : ST_RESULT;
            ST_SRCH_CMP: state_next = ST_SRCH_RD;
            ST_RESULT:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory accesses. An append writes entry count+1, which no
    // read touches until a later item, so no forwarding is needed.
    always_comb
    begin
        req_next    = req_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        est_next    = est_reg;
        x_next      = x_reg;
        prod_next   = prod_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        thr_next    = thr_reg;
        status_next = status_reg;
        answer_next = answer_reg;
        ram_ctl     = '0;
        wr_addr     = count_reg + CNT_W'(1);
        wr_data     = total_reg + SUM_W'(est_reg);
        rd_addr     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                end
            end
            ST_DECODE:
            begin
                status_next = STATUS_OK;
                answer_next = '0;
                case (req_reg.mode)
                    MODE_APPEND_EST:
                    begin
                        est_next = req_reg.given_estimate;
                    end
                    MODE_APPEND_LEN:
                    begin
                        x_next = x_calc;
                    end
                    MODE_SUFFIX_SUM:
                    begin
                        ram_ctl.rd_en = !start_past;
                        rd_addr       = suf_addr_full[ADDR_W-1:0];
                    end
                    MODE_KEEP_RECENT:
                    begin
                        if (keep_direct)
                        begin
                            answer_next = SUM_W'(count_reg);
                        end
                        thr_next = total_reg - req_reg.token_budget;
                        lo_next  = '0;
                        hi_next  = count_reg;
                    end
                    MODE_CLEAR:
                    begin
                        count_next = '0;
                        total_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_EST_MUL:
            begin
                prod_next = PROD_W'(x_reg) * PROD_W'(RECIP);
            end
            ST_EST_FIX:
            begin
                est_next = est_fix;
            end
            ST_APPEND:
            begin
                if (count_reg >= MAX_CNT)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    ram_ctl.wr_en = 1'b1;
                    count_next    = count_reg + CNT_W'(1);
                    total_next    = wr_data;
                end
            end
            ST_SUF_WAIT:
            begin
                answer_next = total_reg - rd_data;
            end
            ST_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_ctl.rd_en = 1'b1;
                    rd_addr       = mid_calc;
                    mid_next      = mid_calc;
                end
                else if (lo_reg == count_reg)
                begin
                    answer_next = SUM_W'(1);
                end
                else
                begin
                    answer_next = SUM_W'(count_reg - lo_reg);
                end
            end
            ST_SRCH_CMP:
            begin
                if (rd_data < thr_reg)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy                 = (state_reg != ST_IDLE);
        done                 = (state_reg == ST_RESULT);
        response.status      = status_reg;
        response.answer      = answer_reg;
        response.entry_count = count_ext[IDX_W-1:0];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        est_reg    <= est_next;
        x_reg      <= x_next;
        prod_reg   <= prod_next;
        mid_reg    <= mid_next;
        thr_reg    <= thr_next;
        status_reg <= status_next;
        answer_reg <= answer_next;
    end

    // Checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("entry count beyond capacity");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && response.status == STATUS_FULL) |-> (count_reg == MAX_CNT))
        else $error("full status with room in the table");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH_RD || state_reg == ST_SRCH_CMP)
            |-> (lo_reg <= hi_reg && hi_reg <= count_reg))
        else $error("search window out of order");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

[tb/tb_token_prefix_sum_table.sv]
// ----------------------------------------------------------------------------
// tb_token_prefix_sum_table
// Self-checking bench for the token prefix-sum table. A directed table walks
// the corner cases: empty table, zero and maximum estimates, clamped and
// out-of-range suffix starts, the keep-recent floor, spare modes and a full
// table. Random operations follow, with budgets and start indexes aimed at
// the stored prefix sums, under several sender idle patterns. Every result
// is checked field by field against a typed value or a local table model.
// ----------------------------------------------------------------------------
module tb_token_prefix_sum_table;

    import tpst_pkg::*;

    localparam int TABLE_DEPTH    = MAX_ENTRIES_DEF;
    localparam int RAND_PER_PHASE = 217;
    localparam int DRAIN_CYCLES   = 40;
    localparam int STALL_LIMIT    = 3000;

    // Spare operation codes, expected to be ignored
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    typedef struct {
        request_t    rq;
        int unsigned reps;
        bit          typed;
        result_t     res;
    } dir_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    request_t request;
    logic     busy;
    logic     done;
    result_t  response;

    // Local copy of the table
    logic [SUM_W-1:0] running_sums [0:TABLE_DEPTH];
    int unsigned      table_count;

    result_t     pending_results[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned stall_cycles;
    int unsigned op_tally [0:7];
    int unsigned full_refusals;
    int unsigned peak_count;

    token_prefix_sum_table #(
        .MAX_ENTRIES (TABLE_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .response (response)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one operation to the local table and return its result
    function automatic result_t table_apply(request_t rq);
        result_t          res;
        logic [SUM_W-1:0] grand;
        logic [SUM_W-1:0] need;
        longint unsigned  len_v;
        longint unsigned  chunks;
        longint unsigned  est;
        int unsigned      first;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        res.status = STATUS_OK;
        res.answer = '0;
        case (rq.mode)
            MODE_APPEND_EST, MODE_APPEND_LEN:
            begin
                if (rq.mode == MODE_APPEND_EST)
                begin
                    est = rq.given_estimate;
                end
                else
                begin
                    len_v  = rq.text_length;
                    chunks = (len_v + LEN_BIAS) >> LEN_SHIFT;
                    est    = (chunks * EST_MUL + EST_BIAS) / EST_DIV;
                end
                if (table_count >= TABLE_DEPTH)
                begin
                    res.status = STATUS_FULL;
                end
                else
                begin
                    running_sums[table_count + 1] = running_sums[table_count] + SUM_W'(est);
                    table_count++;
                end
            end
            MODE_SUFFIX_SUM:
            begin
                // Clamp a start of zero up to the first entry
                first = (rq.first_entry == '0) ? 1 : rq.first_entry;
                if (table_count != 0 && first <= table_count)
                    res.answer = running_sums[table_count] - running_sums[first - 1];
            end
            MODE_KEEP_RECENT:
            begin
                if (table_count != 0)
                begin
                    grand = running_sums[table_count];
                    if (rq.token_budget >= grand)
                    begin
                        res.answer = SUM_W'(table_count);
                    end
                    else
                    begin
                        // Lower bound on the prefix sums, at least one entry kept
                        need = grand - rq.token_budget;
                        lo   = 0;
                        hi   = table_count;
                        while (lo < hi)
                        begin
                            mid = lo + (hi - lo) / 2;
                            if (running_sums[mid] < need)
                                lo = mid + 1;
                            else
                                hi = mid;
                        end
                        first      = (lo + 1 > table_count) ? table_count : lo + 1;
                        res.answer = SUM_W'(table_count - first + 1);
                    end
                end
            end
            MODE_CLEAR:
            begin
                table_count     = 0;
                running_sums[0] = '0;
            end
            default:
            begin
            end
        endcase
        res.entry_count = IDX_W'(table_count);
        return res;
    endfunction

    // Present one item, hold it until taken, then log what it should return
    task automatic send_op(input request_t rq, input bit typed, input result_t typed_res);
        result_t predicted;
        request <= rq;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        predicted = table_apply(rq);
        op_tally[rq.mode]++;
        if (predicted.status == STATUS_FULL)
            full_refusals++;
        if (table_count > peak_count)
            peak_count = table_count;
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Check each result strobe against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: status %0d answer %0d entry_count %0d",
                       response.status, response.answer, response.entry_count);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                checked++;
                if (response.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, response.status);
                    mismatches++;
                end
                if (response.answer !== want.answer)
                begin
                    $error("answer: expected %0d, got %0d", want.answer, response.answer);
                    mismatches++;
                end
                if (response.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, response.entry_count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && ((start && !busy) || done))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("tb_token_prefix_sum_table: done, errors");
            $finish;
        end
    end

    initial
    begin
        dir_row_t         dir_tab [26];
        request_t         rq;
        logic [SUM_W-1:0] base;
        int unsigned      gap_pct [3];
        int unsigned      pick;
        int unsigned      k;

        mismatches    = 0;
        checked       = 0;
        stall_cycles  = 0;
        full_refusals = 0;
        peak_count    = 0;
        table_count   = 0;
        running_sums[0] = '0;
        foreach (op_tally[i])
            op_tally[i] = 0;
        gap_pct = '{0, 60, 27};

        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;

        // Directed rows: typed results only where obvious, the rest predicted
        dir_tab = '{
            '{'{MODE_SUFFIX_SUM, '0, '0, 11'd0, '0}, 1, 1'b1, '{STATUS_OK, '0, 11'd0}},
            '{'{MODE_KEEP_RECENT, '0, '0, '0, '1}, 1, 1'b1, '{STATUS_OK, '0, 11'd0}},
            '{'{MODE_APPEND_EST, '0, 32'd0, '0, '0}, 1, 1'b1, '{STATUS_OK, '0, 11'd1}},
            '{'{MODE_APPEND_LEN, 24'd0, '0, '0, '0}, 1, 1'b1, '{STATUS_OK, '0, 11'd2}},
            '{'{MODE_APPEND_LEN, '1, '0, '0, '0}, 1, 1'b1, '{STATUS_OK, '0, 11'd3}},
            '{'{MODE_APPEND_EST, '0, '1, '0, '0}, 1, 1'b1, '{STATUS_OK, '0, 11'd4}},
            '{'{MODE_APPEND_LEN, 24'd1, '0, '0, '0}, 1, 1'b0, '0},
            '{'{MODE_APPEND_LEN, 24'd5, '0, '0, '0}, 1, 1'b0, '0},
            '{'{MODE_APPEND_EST, '0, 32'd1000, '0, '0}, 1, 1'b0, '0},
            '{'{MODE_SUFFIX_SUM, '0, '0, 11'd0, '0}, 1, 1'b0, '0},
            '{'{MODE_SUFFIX_SUM, '0, '0, 11'd7, '0}, 1, 1'b0, '0},
            '{'{MODE_SUFFIX_SUM, '0, '0, 11'd8, '0}, 1, 1'b1, '{STATUS_OK, '0, 11'd7}},
            '{'{MODE_SUFFIX_SUM, '0, '0, '1, '0}, 1, 1'b1, '{STATUS_OK, '0, 11'd7}},
            '{'{MODE_KEEP_RECENT, '0, '0, '0, 42'd0}, 1, 1'b0, '0},
            '{'{MODE_KEEP_RECENT, '0, '0, '0, 42'd1000}, 1, 1'b0, '0},
            '{'{MODE_KEEP_RECENT, '0, '0, '0, '1}, 1, 1'b1, '{STATUS_OK, 42'd7, 11'd7}},
            '{'{MODE_SPARE_FIRST, '1, '1, '1, '1}, 1, 1'b1, '{STATUS_OK, '0, 11'd7}},
            '{'{MODE_SPARE_LAST, '1, '0, '1, '0}, 1, 1'b1, '{STATUS_OK, '0, 11'd7}},
            '{'{MODE_CLEAR, '0, '0, '0, '0}, 1, 1'b1, '{STATUS_OK, '0, 11'd0}},
            '{'{MODE_APPEND_EST, '0, '1, '0, '0}, TABLE_DEPTH, 1'b0, '0},
            '{'{MODE_APPEND_EST, '0, 32'd1, '0, '0}, 1, 1'b1, '{STATUS_FULL, '0, 11'd1024}},
            '{'{MODE_APPEND_LEN, 24'd100, '0, '0, '0}, 1, 1'b1, '{STATUS_FULL, '0, 11'd1024}},
            '{'{MODE_SUFFIX_SUM, '0, '0, 11'd1, '0}, 1, 1'b0, '0},
            '{'{MODE_KEEP_RECENT, '0, '0, '0, 42'd0}, 1, 1'b0, '0},
            '{'{MODE_KEEP_RECENT, '0, '0, '0, '1}, 1, 1'b1, '{STATUS_OK, 42'd1024, 11'd1024}},
            '{'{MODE_CLEAR, '0, '0, '0, '0}, 1, 1'b1, '{STATUS_OK, '0, 11'd0}}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed rows
        foreach (dir_tab[r])
        begin
            for (int unsigned n = 0; n < dir_tab[r].reps; n++)
                send_op(dir_tab[r].rq, dir_tab[r].typed, dir_tab[r].res);
        end

        // Random operations, one sender idle pattern per phase
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < gap_pct[phase])
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 30 : 4))
                        @(posedge clk);
                end

                // Choose the operation: mostly appends and searches
                pick = $urandom_range(0, 199);
                if (pick < 45)
                    rq.mode = MODE_APPEND_EST;
                else if (pick < 90)
                    rq.mode = MODE_APPEND_LEN;
                else if (pick < 130)
                    rq.mode = MODE_SUFFIX_SUM;
                else if (pick < 190)
                    rq.mode = MODE_KEEP_RECENT;
                else if (pick < 192)
                    rq.mode = MODE_CLEAR;
                else
                    rq.mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));

                // Text length: short, full range or extreme
                case ($urandom_range(0, 9))
                    0: rq.text_length = '0;
                    1: rq.text_length = '1;
                    2, 3, 4: rq.text_length = LEN_W'($urandom);
                    default: rq.text_length = LEN_W'($urandom_range(0, 400));
                endcase

                // Given estimate: small, full range or extreme
                case ($urandom_range(0, 9))
                    0: rq.given_estimate = '0;
                    1: rq.given_estimate = '1;
                    2, 3, 4, 5: rq.given_estimate = $urandom;
                    default: rq.given_estimate = $urandom_range(0, 2000);
                endcase

                // Start index around the current count, now and then anywhere
                case ($urandom_range(0, 5))
                    0: rq.first_entry = '0;
                    1: rq.first_entry = IDX_W'(1);
                    2: rq.first_entry = IDX_W'(table_count);
                    3: rq.first_entry = IDX_W'(table_count + 1);
                    4: rq.first_entry = IDX_W'($urandom_range(0, table_count + 1));
                    default: rq.first_entry = IDX_W'($urandom);
                endcase

                // Budget on or next to a suffix sum boundary, or anywhere
                case ($urandom_range(0, 9))
                    0: rq.token_budget = '0;
                    1: rq.token_budget = SUM_W'({$urandom, $urandom});
                    2: rq.token_budget = running_sums[table_count];
                    default:
                    begin
                        k    = $urandom_range(0, table_count);
                        base = running_sums[table_count] - running_sums[k];
                        rq.token_budget = base + SUM_W'($urandom_range(0, 2)) - SUM_W'(1);
                    end
                endcase

                send_op(rq, 1'b0, '0);
            end
        end

        // Drain outstanding results, then let the block settle
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatches++;
        end

        $display("Ran %0d appends (%0d refused on a full table), %0d suffix sums, %0d keep-recent",
                 op_tally[MODE_APPEND_EST] + op_tally[MODE_APPEND_LEN], full_refusals,
                 op_tally[MODE_SUFFIX_SUM], op_tally[MODE_KEEP_RECENT]);
        $display("searches, %0d clears; table peaked at %0d entries; %0d results checked",
                 op_tally[MODE_CLEAR], peak_count, checked);
        if (mismatches == 0)
            $display("tb_token_prefix_sum_table: done, clean");
        else
            $display("tb_token_prefix_sum_table: done, errors");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/tpst_pkg.sv
hw/rtl/tpst_prefix_ram.sv
hw/rtl/token_prefix_sum_table.sv
tb/tb_token_prefix_sum_table.sv
